[hw/rtl/error_diffusion_dither_packer_macros.svh]
// Assertion macros for the error diffusion dither packer.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ERROR_DIFFUSION_DITHER_PACKER_MACROS_SVH
`define ERROR_DIFFUSION_DITHER_PACKER_MACROS_SVH
`ifndef ASSERT_OFF
`define EDDP_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define EDDP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define EDDP_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define EDDP_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

[hw/rtl/eddp_pkg.sv]
// Shared types, constants and helper functions for the dither packer.
// Depends on nothing.
package eddp_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int ERR_W          = 10;
    localparam int CFG_W          = 10;
    localparam int BANK_COUNT     = 3;

    localparam logic [9:0] WIDTH_RESET  = 10'd320;
    localparam logic [9:0] HEIGHT_RESET = 10'd200;

    localparam logic [7:0] THR_FLOYD    = 8'd127;
    localparam logic [7:0] THR_ATKINSON = 8'd64;

    localparam logic [1:0] CFG_DITHER_MODE  = 2'd0;
    localparam logic [1:0] CFG_LINE_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        MODE_FLOYD,
        MODE_ATKINSON,
        MODE_BAYER,
        MODE_MAP_DIFFUSE
    } mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } result_t;

    localparam logic [7:0] THR_MAP [4][4] = '{
        '{8'd15,  8'd135, 8'd45,  8'd165},
        '{8'd195, 8'd75,  8'd225, 8'd105},
        '{8'd60,  8'd180, 8'd30,  8'd150},
        '{8'd240, 8'd120, 8'd210, 8'd90}
    };

    function automatic logic signed [ERR_W-1:0] sat_add(
        input logic signed [ERR_W-1:0] a,
        input logic signed [ERR_W-1:0] b
    );
        logic signed [ERR_W:0] s;
        s = {a[ERR_W-1], a} + {b[ERR_W-1], b};
        if (s > 11'sd511)
            return 10'sd511;
        else if (s < -11'sd512)
            return -10'sd512;
        else
            return s[ERR_W-1:0];
    endfunction

    function automatic logic signed [ERR_W-1:0] shr_trunc(
        input logic signed [11:0] v,
        input int unsigned        sh
    );
        logic [11:0] mag;
        logic [11:0] q;
        mag = v[11] ? 12'(-v) : 12'(v);
        q = mag >> sh;
        return v[11] ? ERR_W'(-$signed(q)) : ERR_W'($signed(q));
    endfunction

    function automatic logic [1:0] next_bank(input logic [1:0] b);
        return (b == 2'(BANK_COUNT - 1)) ? 2'd0 : b + 2'd1;
    endfunction

endpackage

[hw/rtl/error_diffusion_dither_packer.sv]
// Error diffusion dither packer: grey pixels in, packed 1-bit bytes out.
// Depends on eddp_pkg and error_diffusion_dither_packer_macros.svh.
//
// Pixels arrive on grey_pixel with pixel_valid/pixel_stall in raster order.
// Each accepted pixel is dithered in the cycle it is taken; every eighth
// pixel, and the last pixel of a frame, yields a request on the byte
// channel (packed_byte, frame_last), registered in the output or skid stage.
// Throughput is one pixel per cycle while pixel_stall is low, set by the
// right-neighbor carry loop that feeds the next pixel's working value.
// The row error stores are three rotating banks of MAX_WIDTH entries with
// one write and one registered read each; the bank roles rotate at row end.
// Reset: registers return to their reset values and the stores read as zero
// through the two fill lengths, so no clearing pass is run and a pixel can
// be taken in the first cycle after reset. Frame end empties them likewise.
// When byte_stall holds a result, one more result is kept in a skid stage;
// pixel_stall rises only while that stage is full. Configuration is to be
// written via cfg_we/cfg_index/cfg_data while idle; the block does not enforce it.
module error_diffusion_dither_packer #(
    parameter int MAX_WIDTH  = eddp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = eddp_pkg::MAX_HEIGHT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [eddp_pkg::CFG_W-1:0] cfg_data,
    input  logic                       pixel_valid,
    output logic                       pixel_stall,
    input  logic [7:0]                 grey_pixel,
    output logic                       byte_valid,
    input  logic                       byte_stall,
    output logic [7:0]                 packed_byte,
    output logic                       frame_last
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int SWX = (XW + 1 > eddp_pkg::CFG_W) ? XW + 1 : eddp_pkg::CFG_W;
    localparam int SWY = (YW + 1 > eddp_pkg::CFG_W) ? YW + 1 : eddp_pkg::CFG_W;
    localparam int EW  = eddp_pkg::ERR_W;
    localparam int NB  = eddp_pkg::BANK_COUNT;

    eddp_pkg::mode_t   mode_reg;
    logic [9:0]        width_cfg_reg;
    logic [9:0]        height_cfg_reg;

    logic [XW-1:0]     col_reg, col_next;
    logic [YW-1:0]     row_reg, row_next;
    logic [1:0]        rot_reg, rot_next;
    logic [XW:0]       len_c_reg, len_c_next;
    logic [XW:0]       len_n_reg, len_n_next;
    logic [XW-1:0]     c_raddr_reg, c_raddr_next;
    logic [XW:0]       n_raddr_reg, n_raddr_next;
    logic              tail_valid_reg, tail_valid_next;
    logic [XW-1:0]     tail_addr_reg, tail_addr_next;
    logic signed [EW-1:0] tail_val_reg, tail_val_next;
    logic signed [EW-1:0] p_prev_reg, p_prev_next;
    logic signed [EW-1:0] p_cur_reg, p_cur_next;
    logic signed [EW-1:0] rc1_reg, rc1_next;
    logic signed [EW-1:0] rc2_reg, rc2_next;
    logic signed [EW-1:0] s0_reg, s0_next;
    logic [7:0]        pack_reg, pack_next;
    logic [2:0]        pack_cnt_reg, pack_cnt_next;

    eddp_pkg::result_t out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    eddp_pkg::result_t skid_reg, skid_next;
    logic              skid_valid_reg, skid_valid_next;

    logic                 bank_we    [NB];
    logic [XW-1:0]        bank_waddr [NB];
    logic signed [EW-1:0] bank_wdata [NB];
    logic                 bank_re    [NB];
    logic [XW-1:0]        bank_raddr [NB];
    logic signed [EW-1:0] bank_rdata_reg [NB];

    logic              accept;
    logic [SWX-1:0]    lw_ext;
    logic [SWY-1:0]    lh_ext;
    logic [XW:0]       w_eff;
    logic [YW:0]       h_eff;
    logic [XW:0]       x1, x2;
    logic [YW:0]       y1, y2;
    logic              last_col, r2_ok, down1_ok, down2_ok, frame_end;
    logic [1:0]        n_bank, s_bank;
    logic signed [EW-1:0] c_val, n_val;
    logic signed [11:0] sum;
    logic [7:0]        val, thr;
    logic              white;
    logic signed [8:0] err;
    logic signed [11:0] err12;
    logic signed [EW-1:0] r1, r2, dl, dn, dr, d2;
    logic signed [EW-1:0] r1g, r2g, dlg, dng, drg, d2g;
    logic signed [EW-1:0] entry_x_final, entry_x1;
    logic [7:0]        new_bits;
    logic              emit;
    eddp_pkg::result_t res;
    logic              res_valid;
    logic              out_fire;

    assign accept = pixel_valid && !skid_valid_reg;

    always_comb
    begin
        lw_ext = SWX'(width_cfg_reg);
        lh_ext = SWY'(height_cfg_reg);
        if (width_cfg_reg == '0)
            w_eff = (XW + 1)'(1);
        else if (lw_ext > SWX'(MAX_WIDTH))
            w_eff = (XW + 1)'(MAX_WIDTH);
        else
            w_eff = lw_ext[XW:0];
        if (height_cfg_reg == '0)
            h_eff = (YW + 1)'(1);
        else if (lh_ext > SWY'(MAX_HEIGHT))
            h_eff = (YW + 1)'(MAX_HEIGHT);
        else
            h_eff = lh_ext[YW:0];
    end

    assign x1        = {1'b0, col_reg} + (XW + 1)'(1);
    assign x2        = {1'b0, col_reg} + (XW + 1)'(2);
    assign y1        = {1'b0, row_reg} + (YW + 1)'(1);
    assign y2        = {1'b0, row_reg} + (YW + 1)'(2);
    assign last_col  = x1 >= w_eff;
    assign r2_ok     = x2 < w_eff;
    assign down1_ok  = y1 < h_eff;
    assign down2_ok  = y2 < h_eff;
    assign frame_end = last_col && !down1_ok;

    assign n_bank = eddp_pkg::next_bank(rot_reg);
    assign s_bank = eddp_pkg::next_bank(n_bank);

    always_comb
    begin
        if (tail_valid_reg && (c_raddr_reg == tail_addr_reg))
            c_val = tail_val_reg;
        else if ({1'b0, c_raddr_reg} < len_c_reg)
            c_val = bank_rdata_reg[rot_reg];
        else
            c_val = '0;
        if (n_raddr_reg < len_n_reg)
            n_val = bank_rdata_reg[n_bank];
        else
            n_val = '0;
    end

    always_comb
    begin
        sum = $signed({4'b0000, grey_pixel}) + {{2{c_val[EW-1]}}, c_val}
            + {{2{rc1_reg[EW-1]}}, rc1_reg};
        if (sum < 12'sd0)
            val = 8'd0;
        else if (sum > 12'sd255)
            val = 8'd255;
        else
            val = sum[7:0];

        unique case (mode_reg)
            eddp_pkg::MODE_FLOYD:    thr = eddp_pkg::THR_FLOYD;
            eddp_pkg::MODE_ATKINSON: thr = eddp_pkg::THR_ATKINSON;
            default:                 thr = eddp_pkg::THR_MAP[row_reg[1:0]][col_reg[1:0]];
        endcase

        white = val > thr;
        err   = $signed({1'b0, val}) - (white ? 9'sd255 : 9'sd0);
        err12 = {{3{err[8]}}, err};

        r1 = '0;
        r2 = '0;
        dl = '0;
        dn = '0;
        dr = '0;
        d2 = '0;
        unique case (mode_reg)
            eddp_pkg::MODE_FLOYD:
            begin
                r1 = eddp_pkg::shr_trunc(err12 * 12'sd7, 4);
                dl = eddp_pkg::shr_trunc(err12 * 12'sd3, 4);
                dn = eddp_pkg::shr_trunc(err12 * 12'sd5, 4);
                dr = eddp_pkg::shr_trunc(err12, 4);
            end
            eddp_pkg::MODE_ATKINSON:
            begin
                r1 = eddp_pkg::shr_trunc(err12, 3);
                r2 = r1;
                dl = r1;
                dn = r1;
                dr = r1;
                d2 = r1;
            end
            eddp_pkg::MODE_MAP_DIFFUSE:
            begin
                r1 = eddp_pkg::shr_trunc(err12, 2);
                dl = r1;
                dn = r1;
                dr = r1;
            end
            default:
            begin
                r1 = '0;
            end
        endcase

        r1g = last_col ? '0 : r1;
        r2g = r2_ok ? r2 : '0;
        dlg = (down1_ok && (col_reg != '0)) ? dl : '0;
        dng = down1_ok ? dn : '0;
        drg = (down1_ok && !last_col) ? dr : '0;
        d2g = down2_ok ? d2 : '0;

        entry_x_final = eddp_pkg::sat_add(p_cur_reg, dng);
        entry_x1      = eddp_pkg::sat_add(n_val, drg);
    end

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        rot_next        = rot_reg;
        len_c_next      = len_c_reg;
        len_n_next      = len_n_reg;
        c_raddr_next    = c_raddr_reg;
        n_raddr_next    = n_raddr_reg;
        tail_valid_next = tail_valid_reg;
        tail_addr_next  = tail_addr_reg;
        tail_val_next   = tail_val_reg;
        p_prev_next     = p_prev_reg;
        p_cur_next      = p_cur_reg;
        rc1_next        = rc1_reg;
        rc2_next        = rc2_reg;
        s0_next         = s0_reg;
        pack_next       = pack_reg;
        pack_cnt_next   = pack_cnt_reg;
        new_bits        = {pack_reg[6:0], white};
        emit            = (pack_cnt_reg == 3'd7) || frame_end;
        res.data        = 8'(new_bits << (3'd7 - pack_cnt_reg));
        res.last        = frame_end;
        res_valid       = accept && emit;

        if (accept)
        begin
            pack_next     = emit ? '0 : new_bits;
            pack_cnt_next = emit ? '0 : pack_cnt_reg + 3'd1;
            if (col_reg == '0)
                s0_next = d2g;
            if (!last_col)
            begin
                col_next     = col_reg + XW'(1);
                p_prev_next  = entry_x_final;
                p_cur_next   = entry_x1;
                rc1_next     = eddp_pkg::sat_add(rc2_reg, r1g);
                rc2_next     = r2g;
                c_raddr_next = x1[XW-1:0];
                n_raddr_next = x2;
            end
            else
            begin
                col_next       = '0;
                rc1_next       = '0;
                rc2_next       = '0;
                tail_val_next  = entry_x_final;
                tail_addr_next = col_reg;
                c_raddr_next   = '0;
                n_raddr_next   = (XW + 1)'(1);
                if (frame_end)
                begin
                    row_next        = '0;
                    len_c_next      = '0;
                    len_n_next      = '0;
                    tail_valid_next = 1'b0;
                    p_cur_next      = '0;
                end
                else
                begin
                    row_next        = row_reg + YW'(1);
                    len_c_next      = (len_n_reg > x1) ? len_n_reg : x1;
                    len_n_next      = x1;
                    tail_valid_next = 1'b1;
                    p_cur_next      = (col_reg == '0) ? d2g : s0_reg;
                    rot_next        = n_bank;
                end
            end
        end
    end

    always_comb
    begin
        for (int b = 0; b < NB; b++)
        begin
            bank_we[b]    = 1'b0;
            bank_waddr[b] = col_reg;
            bank_wdata[b] = d2g;
            if (2'(b) == n_bank)
            begin
                bank_we[b]    = accept && (col_reg != '0);
                bank_waddr[b] = col_reg - XW'(1);
                bank_wdata[b] = eddp_pkg::sat_add(p_prev_reg, dlg);
            end
            else if (2'(b) == s_bank)
            begin
                bank_we[b] = accept;
            end
            bank_re[b]    = accept && ((2'(b) == rot_next)
                            || (2'(b) == eddp_pkg::next_bank(rot_next)));
            bank_raddr[b] = (2'(b) == rot_next) ? c_raddr_next : n_raddr_next[XW-1:0];
        end
    end

    for (genvar b = 0; b < NB; b++)
    begin : g_bank
        logic signed [EW-1:0] mem [MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (bank_we[b])
                mem[bank_waddr[b]] <= bank_wdata[b];
            if (bank_re[b])
            begin
                if (bank_we[b] && (bank_waddr[b] == bank_raddr[b]))
                    bank_rdata_reg[b] <= bank_wdata[b];
                else
                    bank_rdata_reg[b] <= mem[bank_raddr[b]];
            end
        end
    end

    assign out_fire = out_valid_reg && !byte_stall;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= eddp_pkg::MODE_FLOYD;
            width_cfg_reg  <= eddp_pkg::WIDTH_RESET;
            height_cfg_reg <= eddp_pkg::HEIGHT_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            rot_reg        <= '0;
            len_c_reg      <= '0;
            len_n_reg      <= '0;
            c_raddr_reg    <= '0;
            n_raddr_reg    <= '0;
            tail_valid_reg <= 1'b0;
            p_cur_reg      <= '0;
            rc1_reg        <= '0;
            rc2_reg        <= '0;
            pack_reg       <= '0;
            pack_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    eddp_pkg::CFG_DITHER_MODE:  mode_reg <= eddp_pkg::mode_t'(cfg_data[1:0]);
                    eddp_pkg::CFG_LINE_WIDTH:   width_cfg_reg <= cfg_data;
                    eddp_pkg::CFG_FRAME_HEIGHT: height_cfg_reg <= cfg_data;
                    default:                    mode_reg <= mode_reg;
                endcase
            end
            col_reg        <= col_next;
            row_reg        <= row_next;
            rot_reg        <= rot_next;
            len_c_reg      <= len_c_next;
            len_n_reg      <= len_n_next;
            c_raddr_reg    <= c_raddr_next;
            n_raddr_reg    <= n_raddr_next;
            tail_valid_reg <= tail_valid_next;
            p_cur_reg      <= p_cur_next;
            rc1_reg        <= rc1_next;
            rc2_reg        <= rc2_next;
            pack_reg       <= pack_next;
            pack_cnt_reg   <= pack_cnt_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_addr_reg <= tail_addr_next;
        tail_val_reg  <= tail_val_next;
        p_prev_reg    <= p_prev_next;
        s0_reg        <= s0_next;
        out_reg       <= out_next;
        skid_reg      <= skid_next;
    end

    assign pixel_stall = skid_valid_reg;
    assign byte_valid  = out_valid_reg;
    assign packed_byte = out_reg.data;
    assign frame_last  = out_reg.last;

`include "error_diffusion_dither_packer_macros.svh"

    `EDDP_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `EDDP_ASSERT_NEXT(a_frame_end_result, clk, rst_n, accept && frame_end, out_valid_reg)
    `EDDP_ASSERT_NEXT(a_frame_end_pack_clear, clk, rst_n, accept && frame_end, pack_cnt_reg == 3'd0)
    `EDDP_ASSERT_SAME(a_tail_in_fill, clk, rst_n, tail_valid_reg, {1'b0, tail_addr_reg} < len_c_reg)

endmodule

[sim/tb_error_diffusion_dither_packer.sv]
// Self-checking testbench for error_diffusion_dither_packer: directed table, wide row, random frames.
// Bytes are predicted pixel by pixel or preset in the table, and compared in order as they come out.
// Depends on eddp_pkg and the RTL of the block.
module tb_error_diffusion_dither_packer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int ITEM_TARGET    = 1550;
    localparam int WIDE_RUN       = 520;
    localparam int PIX_MAX        = 512;
    localparam int ROWS_MAX       = 512;
    localparam int DIR_ROWS       = 24;

    localparam logic [9:0] WIDTH_AT_RESET  = 10'd320;
    localparam logic [9:0] HEIGHT_AT_RESET = 10'd200;
    localparam logic [1:0] CFG_UNUSED      = 2'd3;

    localparam int THRESH_MAP [4][4] = '{
        '{15, 135, 45, 165},
        '{195, 75, 225, 105},
        '{60, 180, 30, 150},
        '{240, 120, 210, 90}
    };

    typedef struct packed {
        eddp_pkg::mode_t mode;
        logic [9:0]      width;
        logic [9:0]      height;
        logic [7:0]      grey;
        logic            preset;
        logic [7:0]      data;
        logic            last;
    } stim_row_t;

    stim_row_t dir_table [DIR_ROWS] = '{
        '{eddp_pkg::MODE_FLOYD,       10'd1,    10'd1,    8'd255, 1'b1, 8'h80, 1'b1},
        '{eddp_pkg::MODE_FLOYD,       10'd1,    10'd1,    8'd0,   1'b1, 8'h00, 1'b1},
        '{eddp_pkg::MODE_FLOYD,       10'd1,    10'd1,    8'd127, 1'b1, 8'h00, 1'b1},
        '{eddp_pkg::MODE_FLOYD,       10'd1,    10'd1,    8'd128, 1'b1, 8'h80, 1'b1},
        '{eddp_pkg::MODE_ATKINSON,    10'd1,    10'd1,    8'd64,  1'b1, 8'h00, 1'b1},
        '{eddp_pkg::MODE_ATKINSON,    10'd1,    10'd1,    8'd65,  1'b1, 8'h80, 1'b1},
        '{eddp_pkg::MODE_BAYER,       10'd1,    10'd1,    8'd15,  1'b1, 8'h00, 1'b1},
        '{eddp_pkg::MODE_BAYER,       10'd1,    10'd1,    8'd16,  1'b1, 8'h80, 1'b1},
        '{eddp_pkg::MODE_MAP_DIFFUSE, 10'd1,    10'd1,    8'd16,  1'b1, 8'h80, 1'b1},
        '{eddp_pkg::MODE_MAP_DIFFUSE, 10'd1,    10'd1,    8'd15,  1'b1, 8'h00, 1'b1},
        '{eddp_pkg::MODE_FLOYD,       10'd0,    10'd0,    8'd200, 1'b1, 8'h80, 1'b1},
        '{eddp_pkg::MODE_FLOYD,       10'd1023, 10'd1023, 8'd0,   1'b0, 8'h00, 1'b0},
        '{eddp_pkg::MODE_FLOYD,       10'd1023, 10'd1023, 8'd255, 1'b0, 8'h00, 1'b0},
        '{eddp_pkg::MODE_FLOYD,       10'd1023, 10'd1023, 8'd100, 1'b0, 8'h00, 1'b0},
        '{eddp_pkg::MODE_FLOYD,       10'd1023, 10'd1023, 8'd200, 1'b0, 8'h00, 1'b0},
        '{eddp_pkg::MODE_FLOYD,       10'd1023, 10'd1023, 8'd128, 1'b0, 8'h00, 1'b0},
        '{eddp_pkg::MODE_FLOYD,       10'd1023, 10'd1023, 8'd127, 1'b0, 8'h00, 1'b0},
        '{eddp_pkg::MODE_FLOYD,       10'd1023, 10'd1023, 8'd1,   1'b0, 8'h00, 1'b0},
        '{eddp_pkg::MODE_FLOYD,       10'd1023, 10'd1023, 8'd254, 1'b0, 8'h00, 1'b0},
        '{eddp_pkg::MODE_ATKINSON,    10'd2,    10'd1023, 8'd90,  1'b0, 8'h00, 1'b0},
        '{eddp_pkg::MODE_ATKINSON,    10'd2,    10'd1023, 8'd30,  1'b0, 8'h00, 1'b0},
        '{eddp_pkg::MODE_ATKINSON,    10'd2,    10'd1023, 8'd255, 1'b0, 8'h00, 1'b0},
        '{eddp_pkg::MODE_ATKINSON,    10'd2,    10'd1023, 8'd64,  1'b0, 8'h00, 1'b0},
        '{eddp_pkg::MODE_MAP_DIFFUSE, 10'd513,  10'd2,    8'd77,  1'b0, 8'h00, 1'b0}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [9:0] cfg_data = '0;
    logic       pixel_valid = 1'b0;
    logic       pixel_stall;
    logic [7:0] grey_pixel = '0;
    logic       byte_valid;
    logic       byte_stall = 1'b0;
    logic [7:0] packed_byte;
    logic       frame_last;

    eddp_pkg::mode_t mode_reg = eddp_pkg::MODE_FLOYD;
    logic [9:0]      line_w = WIDTH_AT_RESET;
    logic [9:0]      frame_h = HEIGHT_AT_RESET;

    int cur_err [PIX_MAX];
    int nxt_err [PIX_MAX];
    int sec_err [PIX_MAX];
    int carry_one;
    int carry_two;
    int col_pos;
    int row_pos;
    int pack_bits;
    int pack_count;

    eddp_pkg::result_t pending_bytes [$];
    int                mismatch_count = 0;
    int                pixels_sent = 0;
    bit                no_gaps = 1'b0;

    error_diffusion_dither_packer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .grey_pixel  (grey_pixel),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .packed_byte (packed_byte),
        .frame_last  (frame_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic clear_rows();
        for (int i = 0; i < PIX_MAX; i++)
        begin
            cur_err[i] = 0;
            nxt_err[i] = 0;
            sec_err[i] = 0;
        end
        carry_one = 0;
        carry_two = 0;
    endtask

    task automatic dither_pixel(input logic [7:0] g, output bit has_byte,
                                output eddp_pkg::result_t r);
        int  w, h, x, y, val, thr, err;
        int  sr1, sr2, sdl, sdn, sdr, sd2;
        bit  white, row_end, frame_end;
        w = (line_w == 0) ? 1 : ((int'(line_w) > PIX_MAX) ? PIX_MAX : int'(line_w));
        h = (frame_h == 0) ? 1 : ((int'(frame_h) > ROWS_MAX) ? ROWS_MAX : int'(frame_h));
        x = col_pos;
        y = row_pos;
        val = clip(int'(g) + cur_err[x] + carry_one, 0, 255);
        case (mode_reg)
            eddp_pkg::MODE_FLOYD:    thr = 127;
            eddp_pkg::MODE_ATKINSON: thr = 64;
            default:                 thr = THRESH_MAP[y & 3][x & 3];
        endcase
        white = (val > thr);
        err = val - (white ? 255 : 0);
        sr1 = 0; sr2 = 0; sdl = 0; sdn = 0; sdr = 0; sd2 = 0;
        case (mode_reg)
            eddp_pkg::MODE_FLOYD:
            begin
                sr1 = err * 7 / 16;
                sdl = err * 3 / 16;
                sdn = err * 5 / 16;
                sdr = err / 16;
            end
            eddp_pkg::MODE_ATKINSON:
            begin
                sr1 = err / 8;
                sr2 = sr1; sdl = sr1; sdn = sr1; sdr = sr1; sd2 = sr1;
            end
            eddp_pkg::MODE_MAP_DIFFUSE:
            begin
                sr1 = err / 4;
                sdl = sr1; sdn = sr1; sdr = sr1;
            end
            default: ;
        endcase
        if (x + 1 >= w) sr1 = 0;
        if (x + 2 >= w) sr2 = 0;
        carry_one = clip(carry_two + sr1, -512, 511);
        carry_two = sr2;
        if (y + 1 < h)
        begin
            if (x >= 1) nxt_err[x - 1] = clip(nxt_err[x - 1] + sdl, -512, 511);
            nxt_err[x] = clip(nxt_err[x] + sdn, -512, 511);
            if (x + 1 < w) nxt_err[x + 1] = clip(nxt_err[x + 1] + sdr, -512, 511);
        end
        if (y + 2 < h)
            sec_err[x] = clip(sec_err[x] + sd2, -512, 511);
        pack_bits = ((pack_bits << 1) | int'(white)) & 255;
        pack_count++;
        row_end = (x + 1 >= w);
        frame_end = row_end && (y + 1 >= h);
        if (row_end)
        begin
            col_pos = 0;
            carry_one = 0;
            carry_two = 0;
            if (frame_end)
            begin
                row_pos = 0;
                clear_rows();
            end
            else
            begin
                row_pos = y + 1;
                for (int i = 0; i < PIX_MAX; i++)
                begin
                    cur_err[i] = nxt_err[i];
                    nxt_err[i] = sec_err[i];
                    sec_err[i] = 0;
                end
            end
        end
        else
            col_pos = x + 1;
        has_byte = 1'b0;
        r = '0;
        if (pack_count >= 8 || frame_end)
        begin
            has_byte = 1'b1;
            r.data = 8'(pack_bits << (8 - pack_count));
            r.last = frame_end;
            pack_bits = 0;
            pack_count = 0;
        end
    endtask

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatch_count++;
    endtask

    // drop valid and wait out every pending byte plus the pipeline
    task automatic settle();
        pixel_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [9:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            eddp_pkg::CFG_DITHER_MODE:  mode_reg = eddp_pkg::mode_t'(data[1:0]);
            eddp_pkg::CFG_LINE_WIDTH:   line_w = data;
            eddp_pkg::CFG_FRAME_HEIGHT: frame_h = data;
            default: ;
        endcase
    endtask

    task automatic load_settings(input eddp_pkg::mode_t m, input logic [9:0] w,
                                 input logic [9:0] h, input bit force_all,
                                 input logic [7:0] mode_hi, input bit poke_unused);
        if (!force_all && !poke_unused && m == mode_reg && w == line_w && h == frame_h)
            return;
        settle();
        if (force_all || m != mode_reg)
            reg_write(eddp_pkg::CFG_DITHER_MODE, {mode_hi, m});
        if (force_all || w != line_w)
            reg_write(eddp_pkg::CFG_LINE_WIDTH, w);
        if (force_all || h != frame_h)
            reg_write(eddp_pkg::CFG_FRAME_HEIGHT, h);
        if (poke_unused)
            reg_write(CFG_UNUSED, 10'($urandom_range(0, 1023)));
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] g, input bit preset,
                              input eddp_pkg::result_t given);
        bit                has_byte;
        eddp_pkg::result_t got;
        int                gap;
        dither_pixel(g, has_byte, got);
        if (has_byte)
            pending_bytes.push_back(preset ? given : got);
        pixel_valid <= 1'b1;
        grey_pixel <= g;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        pixels_sent++;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [9:0] pick_size(input int near, input int far);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 10'($urandom_range(1, near));
        if (r == 7)
        begin
            case ($urandom_range(0, 3))
                0:       return 10'd0;
                1:       return 10'd512;
                2:       return 10'd513;
                default: return 10'd1023;
            endcase
        end
        return 10'($urandom_range(near + 1, far));
    endfunction

    function automatic logic [7:0] pick_grey();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(56, 72));
            3:       return 8'($urandom_range(120, 135));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin : byte_sink
        int                hold;
        eddp_pkg::result_t want;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            hold = no_gaps ? 0 : $urandom_range(0, 3);
            if (hold > 0)
            begin
                byte_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            byte_stall <= 1'b0;
            @(posedge clk);
            while (!byte_valid)
                @(posedge clk);
            if (pending_bytes.size() == 0)
                flag_mismatch($sformatf("byte %02h last %0b with nothing pending",
                                        packed_byte, frame_last));
            else
            begin
                want = pending_bytes.pop_front();
                if (packed_byte !== want.data)
                    flag_mismatch($sformatf("packed_byte %02h, predicted %02h",
                                            packed_byte, want.data));
                if (frame_last !== want.last)
                    flag_mismatch($sformatf("frame_last %0b, predicted %0b on byte %02h",
                                            frame_last, want.last, want.data));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_valid && !pixel_stall) || (byte_valid && !byte_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("TIMEOUT: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        int n;
        clear_rows();
        col_pos = 0;
        row_pos = 0;
        pack_bits = 0;
        pack_count = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            load_settings(dir_table[i].mode, dir_table[i].width, dir_table[i].height,
                          1'b0, 8'h00, 1'b0);
            send_pixel(dir_table[i].grey, dir_table[i].preset,
                       eddp_pkg::result_t'({dir_table[i].data, dir_table[i].last}));
        end

        // one pass across a full-width row, into the second row
        load_settings(eddp_pkg::mode_t'($urandom_range(0, 3)), 10'd512, 10'd1023, 1'b1,
                      8'hFF, 1'b1);
        repeat (WIDE_RUN) send_pixel(pick_grey(), 1'b0, '0);

        while (pixels_sent < ITEM_TARGET)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            load_settings(eddp_pkg::mode_t'($urandom_range(0, 3)), pick_size(20, 80),
                          pick_size(6, 12), $urandom_range(0, 3) == 0,
                          8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            n = $urandom_range(8, 64);
            repeat (n) send_pixel(pick_grey(), 1'b0, '0);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
